// File: sv/pcn_pkg.sv
`default_nettype none

package pcn_pkg;

	// field widths
	localparam int POS_W   = 24;
	localparam int ELEM_W  = 7;
	localparam int CUT_W   = 23;
	localparam int SUM_W   = 24;
	localparam int RAD_W   = 16;
	localparam int IDXO_W  = 6;
	localparam int R2_W    = 50;
	localparam int ROOT_W  = 26;
	localparam int CNT_PW  = 17;
	localparam int DNUM_W  = 48;
	localparam int DDEN_W  = 32;

	// numeric constants
	localparam int unsigned ELEMENT_COUNT = 86;
	localparam int unsigned SQRT_STEPS    = 26;
	localparam logic [22:0] RAD_SCALE     = 23'd6763593;
	localparam logic [16:0] PAIR_ONE      = 17'h10000;
	localparam logic [16:0] SHIFT_2BOHR   = 17'd8192;
	localparam logic [15:0] LN2_Q16       = 16'd45426;
	localparam logic [16:0] LN2_RECIP     = 17'(34'h1_0000_0000 / 34'd45426);
	localparam logic [21:0] ARG_CLAMP     = 22'h200000;
	localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
	localparam logic [SUM_W-1:0] SUM_MAX  = 24'hFF_FFFF;
	localparam logic [3:0]  KSTEEP        = 4'd10;

	// covalent radii in hundredths of an Angstrom, by atomic number
	localparam logic [7:0] RAD_ROM [0:86] = '{
		8'd0,
		8'd32, 8'd46,
		8'd120, 8'd94, 8'd77, 8'd75, 8'd71, 8'd63, 8'd64, 8'd67,
		8'd140, 8'd125, 8'd113, 8'd104, 8'd110, 8'd102, 8'd99, 8'd96,
		8'd176, 8'd154,
		8'd133, 8'd122, 8'd121, 8'd110, 8'd107, 8'd104, 8'd100, 8'd99, 8'd101, 8'd109,
		8'd112, 8'd109, 8'd115, 8'd110, 8'd114, 8'd117,
		8'd189, 8'd167,
		8'd147, 8'd139, 8'd132, 8'd124, 8'd115, 8'd113, 8'd113, 8'd108, 8'd115, 8'd123,
		8'd128, 8'd126, 8'd126, 8'd123, 8'd132, 8'd131,
		8'd209, 8'd176,
		8'd162, 8'd147, 8'd158, 8'd157, 8'd156, 8'd155, 8'd151,
		8'd152, 8'd151, 8'd150, 8'd149, 8'd149, 8'd148, 8'd153,
		8'd146, 8'd137, 8'd131, 8'd123, 8'd118,
		8'd116, 8'd111, 8'd112, 8'd113, 8'd132,
		8'd130, 8'd130, 8'd136, 8'd131, 8'd138, 8'd142
	};

	// one stored atom: position and scaled radius
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [RAD_W-1:0]        rad;
	} atom_rec_t;

	function automatic logic elem_ok(input logic [ELEM_W-1:0] e);
		return (e >= 7'd1) && (e <= 7'(ELEMENT_COUNT));
	endfunction

	// Q4.12 Bohr radius times 4/3, zero for unsupported elements
	function automatic logic [RAD_W-1:0] elem_radius(input logic [ELEM_W-1:0] e);
		logic [7:0]  h;
		logic [31:0] p;
		h = 8'd0;
		if (elem_ok(e)) begin
			h = RAD_ROM[e];
		end
		p = 32'(h) * 32'(RAD_SCALE) + 32'd32768;
		return p[RAD_W+15:16];
	endfunction

	// floor(2^32 / k) for the series divisors
	function automatic logic [32:0] recip_k(input logic [3:0] k);
		logic [32:0] r;
		unique case (k)
			4'd1:    r = 33'h1_0000_0000;
			4'd2:    r = 33'd2147483648;
			4'd3:    r = 33'd1431655765;
			4'd4:    r = 33'd1073741824;
			4'd5:    r = 33'd858993459;
			4'd6:    r = 33'd715827882;
			4'd7:    r = 33'd613566756;
			4'd8:    r = 33'd536870912;
			4'd9:    r = 33'd477218588;
			4'd10:   r = 33'd429496729;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/pcn_div.sv
`default_nettype none

module pcn_div import pcn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DNUM_W-1:0] num,
	input  logic [DDEN_W-1:0] den,
	output logic              done,
	output logic [DNUM_W-1:0] quo
);

	localparam int STEP_W = $clog2(DNUM_W);

	logic [DDEN_W:0]   rem_q;
	logic [DNUM_W-1:0] quo_q;
	logic [DDEN_W-1:0] den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DDEN_W:0]   shifted;
	logic              fits;

	// restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q[DDEN_W-1:0], quo_q[DNUM_W-1]};
		fits    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DNUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[DNUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// File: sv/pcn_sqrt.sv
`default_nettype none

module pcn_sqrt import pcn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [R2_W-1:0]   val,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [R2_W-1:0] v_q;
	logic [R2_W+1:0] res_q;
	logic [R2_W:0]   bit_q;
	logic [4:0]      step_q;
	logic            busy_q;
	logic            done_q;

	logic [R2_W+1:0] trial;
	logic            ge;

	// one result bit per cycle
	always_comb begin
		trial = res_q + {1'b0, bit_q};
		ge    = {2'b00, v_q} >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= val;
			res_q <= '0;
			bit_q <= {1'b1, {R2_W{1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				v_q   <= v_q - trial[R2_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

`default_nettype wire

// File: sv/pcn_pair.sv
`default_nettype none

module pcn_pair import pcn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [R2_W-1:0]   r2,
	input  logic [CNT_PW-1:0] r0,
	output logic              done,
	output logic [CNT_PW-1:0] count
);

	typedef enum logic [3:0] {
		PS_IDLE, PS_SQRT, PS_DIV, PS_ARG, PS_NQ, PS_NC,
		PS_HM, PS_HK, PS_HC, PS_SIG, PS_SDIV, PS_MUL
	} pair_state_t;

	pair_state_t       state_q;
	logic [CNT_PW-1:0] r0_q;
	logic [ROOT_W-1:0] root_q;
	logic              sel_q;
	logic [32:0]       q_q;
	logic              neg_q;
	logic [21:0]       x_q;
	logic [5:0]        n_q;
	logic [29:0]       f30_q;
	logic [30:0]       res_q;
	logic [60:0]       prod_q;
	logic [30:0]       t_q;
	logic [63:0]       tm_q;
	logic [3:0]        k_q;
	logic [16:0]       s1_q;
	logic [16:0]       s2_q;
	logic [CNT_PW-1:0] count_q;
	logic              done_q;
	logic              sq_start_q;
	logic              dv_start_q;
	logic [DNUM_W-1:0] dv_num_q;
	logic [DDEN_W-1:0] dv_den_q;

	logic              sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic              dv_done;
	logic [DNUM_W-1:0] dv_quo;

	logic signed [34:0] dq;
	logic signed [40:0] dqx;
	logic signed [40:0] arg;
	logic [40:0]        amag;
	logic [21:0]        xc;
	logic [38:0]        nprod;
	logic [21:0]        nl;
	logic [21:0]        rem0;
	logic               rfix;
	logic [60:0]        hprod;
	logic [63:0]        tmul;
	logic [30:0]        q0;
	logic [34:0]        chk;
	logic [30:0]        qf;
	logic [30:0]        e;
	logic [30:0]        snum;
	logic [31:0]        sden;
	logic [DNUM_W-1:0]  sdiv;
	logic [33:0]        sprod;

	pcn_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.val    (r2),
		.done   (sq_done),
		.root   (sq_root)
	);

	pcn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start_q),
		.num    (dv_num_q),
		.den    (dv_den_q),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	// steepness (10, or 20 on the second pass) times (ratio - 1), magnitude clamped
	always_comb begin
		dq   = $signed({2'b00, q_q}) - 35'sd65536;
		dqx  = {{6{dq[34]}}, dq};
		arg  = sel_q ? ((dqx <<< 4) + (dqx <<< 2)) : ((dqx <<< 3) + (dqx <<< 1));
		amag = arg[40] ? 41'(-arg) : 41'(arg);
		xc   = (amag > 41'(ARG_CLAMP)) ? ARG_CLAMP : amag[21:0];
	end

	// split into multiples of ln2 and a fraction
	always_comb begin
		nprod = 39'(x_q) * 39'(LN2_RECIP);
		nl    = 22'(n_q) * 22'(LN2_Q16);
		rem0  = x_q - nl;
		rfix  = rem0 >= 22'(LN2_Q16);
	end

	// one series step: multiply, then divide by k via reciprocal
	always_comb begin
		hprod = 61'(f30_q) * 61'(res_q);
		tmul  = 64'(prod_q[60:30]) * 64'(recip_k(k_q));
		q0    = tm_q[62:32];
		chk   = 35'(t_q) - 35'(q0) * 35'(k_q);
		qf    = (chk >= 35'(k_q)) ? q0 + 31'd1 : q0;
	end

	// logistic division operands and final product
	always_comb begin
		e     = (n_q > 6'd30) ? 31'd0 : (res_q >> n_q);
		snum  = neg_q ? e : ONE_Q30;
		sden  = 32'(ONE_Q30) + 32'(e);
		sdiv  = {1'b0, snum, 16'b0} + DNUM_W'(sden >> 1);
		sprod = 34'(s1_q) * 34'(s2_q) + 34'd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PS_IDLE;
			done_q     <= 1'b0;
			sq_start_q <= 1'b0;
			dv_start_q <= 1'b0;
			sel_q      <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			sq_start_q <= 1'b0;
			dv_start_q <= 1'b0;
			unique case (state_q)
				PS_IDLE: begin
					if (start) begin
						r0_q       <= r0;
						sel_q      <= 1'b0;
						sq_start_q <= 1'b1;
						state_q    <= PS_SQRT;
					end
				end
				PS_SQRT: begin
					if (sq_done) begin
						root_q <= sq_root;
						if (sq_root == '0) begin
							count_q <= PAIR_ONE;
							done_q  <= 1'b1;
							state_q <= PS_IDLE;
						end else begin
							dv_num_q   <= {15'b0, r0_q, 16'b0};
							dv_den_q   <= DDEN_W'(sq_root);
							dv_start_q <= 1'b1;
							state_q    <= PS_DIV;
						end
					end
				end
				PS_DIV: begin
					if (dv_done) begin
						q_q     <= dv_quo[32:0];
						state_q <= PS_ARG;
					end
				end
				PS_ARG: begin
					neg_q   <= arg[40];
					x_q     <= xc;
					state_q <= PS_NQ;
				end
				PS_NQ: begin
					n_q     <= nprod[37:32];
					state_q <= PS_NC;
				end
				PS_NC: begin
					if (rfix) begin
						n_q   <= n_q + 6'd1;
						f30_q <= {16'(rem0 - 22'(LN2_Q16)), 14'b0};
					end else begin
						f30_q <= {rem0[15:0], 14'b0};
					end
					res_q   <= ONE_Q30;
					k_q     <= KSTEEP;
					state_q <= PS_HM;
				end
				PS_HM: begin
					prod_q  <= hprod;
					state_q <= PS_HK;
				end
				PS_HK: begin
					t_q     <= prod_q[60:30];
					tm_q    <= tmul;
					state_q <= PS_HC;
				end
				PS_HC: begin
					res_q <= ONE_Q30 - qf;
					if (k_q == 4'd1) begin
						state_q <= PS_SIG;
					end else begin
						k_q     <= k_q - 4'd1;
						state_q <= PS_HM;
					end
				end
				PS_SIG: begin
					dv_num_q   <= sdiv;
					dv_den_q   <= sden;
					dv_start_q <= 1'b1;
					state_q    <= PS_SDIV;
				end
				PS_SDIV: begin
					if (dv_done) begin
						if (!sel_q) begin
							s1_q       <= dv_quo[16:0];
							sel_q      <= 1'b1;
							dv_num_q   <= {15'b0, r0_q + SHIFT_2BOHR, 16'b0};
							dv_den_q   <= DDEN_W'(root_q);
							dv_start_q <= 1'b1;
							state_q    <= PS_DIV;
						end else begin
							s2_q    <= dv_quo[16:0];
							state_q <= PS_MUL;
						end
					end
				end
				PS_MUL: begin
					count_q <= sprod[32:16];
					done_q  <= 1'b1;
					state_q <= PS_IDLE;
				end
				default: state_q <= PS_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign count = count_q;

endmodule

`default_nettype wire

// File: sv/pairwise_coordination_number.sv
// Loading: one atom per cycle while idle.
// After the last atom, each row is processed in turn; a pair outside the cutoff skips the
// pair unit, while a pair inside it runs the 26-step root, the shared 48-step divider
// (run four times per pair) and the series; each result is then read and registered.
// Reset (arst_n, asynchronous, active low) clears control state and sets the cutoff to
// 40 Bohr; the atom and sum memories are not cleared.
`default_nettype none

module pairwise_coordination_number import pcn_pkg::*; #(
	parameter int MAX_ATOMS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CUT_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic [ELEM_W-1:0]        element_number,
	input  logic                     last_atom,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDXO_W-1:0]        atom_index,
	output logic [SUM_W-1:0]         coord_number,
	output logic                     bad_element,
	output logic                     last_result
);

	localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CNT_W = $clog2(MAX_ATOMS + 1);

	typedef enum logic [3:0] {
		ST_LOAD, ST_ROW_RD, ST_ROW_LAT, ST_PAIR_RD, ST_PAIR_LAT, ST_PAIR_SQ,
		ST_PAIR_CMP, ST_PAIR_WAIT, ST_ROW_END, ST_EMIT_RD, ST_EMIT_LAT, ST_EMIT_ERR
	} state_t;

	state_t                   state_q;
	logic [CUT_W-1:0]         cutoff_q;
	logic [2*CUT_W-1:0]       cut2_q;
	logic [CNT_W-1:0]         count_q;
	logic                     err_q;
	logic [IDX_W-1:0]         i_q;
	logic [IDX_W-1:0]         j_q;
	logic [IDX_W-1:0]         o_q;
	atom_rec_t                atom_i_q;
	logic [SUM_W-1:0]         acc_q;
	logic [RAD_W-1:0]         rad_j_q;
	logic [SUM_W-1:0]         sum_j_q;
	logic signed [POS_W:0]    dx_q;
	logic signed [POS_W:0]    dy_q;
	logic signed [POS_W:0]    dz_q;
	logic [R2_W-1:0]          sqx_q;
	logic [R2_W-1:0]          sqy_q;
	logic [R2_W-1:0]          sqz_q;
	logic                     out_valid_q;
	logic [IDXO_W-1:0]        atom_index_q;
	logic [SUM_W-1:0]         coord_number_q;
	logic                     bad_element_q;
	logic                     last_result_q;

	// memories
	atom_rec_t                atom_mem [MAX_ATOMS];
	logic [SUM_W-1:0]         sum_mem  [MAX_ATOMS];
	atom_rec_t                atom_rdata_q;
	logic [SUM_W-1:0]         sum_rdata_q;

	logic                     in_acc;
	logic                     out_acc;
	logic                     out_free;
	logic                     room;
	logic                     atom_we;
	atom_rec_t                atom_wdata;
	logic [IDX_W-1:0]         atom_raddr;
	logic                     sum_we;
	logic [IDX_W-1:0]         sum_waddr;
	logic [SUM_W-1:0]         sum_wdata;
	logic [IDX_W-1:0]         sum_raddr;
	logic [R2_W-1:0]          r2;
	logic [CNT_PW-1:0]        r0;
	logic                     pair_start;
	logic                     pair_done;
	logic [CNT_PW-1:0]        pair_count;
	logic [SUM_W:0]           sum_j_new;
	logic [SUM_W:0]           acc_new;
	logic                     j_last;
	logic                     i_last;
	logic                     o_last;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid_q && out_ready;
	assign out_free = !out_valid_q || out_ready;
	assign room     = count_q < CNT_W'(MAX_ATOMS);

	// pair datapath terms
	always_comb begin
		r2         = sqx_q + sqy_q + sqz_q;
		r0         = CNT_PW'(atom_i_q.rad) + CNT_PW'(rad_j_q);
		pair_start = (state_q == ST_PAIR_CMP) && (r2 <= R2_W'(cut2_q));
		sum_j_new  = (SUM_W+1)'(sum_j_q) + (SUM_W+1)'(pair_count);
		acc_new    = (SUM_W+1)'(acc_q) + (SUM_W+1)'(pair_count);
		j_last     = CNT_W'(j_q) + CNT_W'(1) == CNT_W'(i_q);
		i_last     = CNT_W'(i_q) + CNT_W'(1) == count_q;
		o_last     = CNT_W'(o_q) + CNT_W'(1) == count_q;
	end

	// memory port control
	always_comb begin
		atom_we        = in_acc && room;
		atom_wdata.x   = pos_x;
		atom_wdata.y   = pos_y;
		atom_wdata.z   = pos_z;
		atom_wdata.rad = elem_radius(element_number);
		atom_raddr     = (state_q == ST_ROW_RD) ? i_q : j_q;
		sum_raddr      = (state_q == ST_EMIT_RD) ? o_q : j_q;
		sum_we         = 1'b0;
		sum_waddr      = j_q;
		sum_wdata      = (sum_j_new > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_j_new[SUM_W-1:0];
		if (state_q == ST_PAIR_WAIT && pair_done) begin
			sum_we = 1'b1;
		end else if (state_q == ST_ROW_END) begin
			sum_we    = 1'b1;
			sum_waddr = i_q;
			sum_wdata = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (atom_we) begin
			atom_mem[count_q[IDX_W-1:0]] <= atom_wdata;
		end
		atom_rdata_q <= atom_mem[atom_raddr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		sum_rdata_q <= sum_mem[sum_raddr];
	end

	pcn_pair u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pair_start),
		.r2     (r2),
		.r0     (r0),
		.done   (pair_done),
		.count  (pair_count)
	);

	// cutoff register and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= 23'd163840;
		end else if (cfg_we) begin
			cutoff_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		cut2_q <= (2*CUT_W)'(cutoff_q) * (2*CUT_W)'(cutoff_q);
	end

	// pair geometry pipeline
	always_ff @(posedge clk) begin
		if (state_q == ST_PAIR_LAT) begin
			dx_q    <= (POS_W+1)'(atom_i_q.x) - (POS_W+1)'(atom_rdata_q.x);
			dy_q    <= (POS_W+1)'(atom_i_q.y) - (POS_W+1)'(atom_rdata_q.y);
			dz_q    <= (POS_W+1)'(atom_i_q.z) - (POS_W+1)'(atom_rdata_q.z);
			rad_j_q <= atom_rdata_q.rad;
			sum_j_q <= sum_rdata_q;
		end
		if (state_q == ST_PAIR_SQ) begin
			sqx_q <= R2_W'(dx_q * dx_q);
			sqy_q <= R2_W'(dy_q * dy_q);
			sqz_q <= R2_W'(dz_q * dz_q);
		end
		if (state_q == ST_ROW_LAT) begin
			atom_i_q <= atom_rdata_q;
		end
	end

	// main sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			count_q       <= '0;
			err_q         <= 1'b0;
			i_q           <= '0;
			j_q           <= '0;
			o_q           <= '0;
			acc_q         <= '0;
			out_valid_q   <= 1'b0;
			atom_index_q  <= '0;
			coord_number_q <= '0;
			bad_element_q <= 1'b0;
			last_result_q <= 1'b0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (room && !elem_ok(element_number)) begin
							err_q <= 1'b1;
						end
						if (last_atom) begin
							i_q <= '0;
							if (err_q || (room && !elem_ok(element_number))) begin
								state_q <= ST_EMIT_ERR;
							end else begin
								state_q <= ST_ROW_RD;
							end
						end
					end
				end
				ST_ROW_RD: state_q <= ST_ROW_LAT;
				ST_ROW_LAT: begin
					acc_q <= '0;
					j_q   <= '0;
					state_q <= (i_q == '0) ? ST_ROW_END : ST_PAIR_RD;
				end
				ST_PAIR_RD:  state_q <= ST_PAIR_LAT;
				ST_PAIR_LAT: state_q <= ST_PAIR_SQ;
				ST_PAIR_SQ:  state_q <= ST_PAIR_CMP;
				ST_PAIR_CMP: begin
					if (pair_start) begin
						state_q <= ST_PAIR_WAIT;
					end else if (j_last) begin
						state_q <= ST_ROW_END;
					end else begin
						j_q     <= j_q + IDX_W'(1);
						state_q <= ST_PAIR_RD;
					end
				end
				ST_PAIR_WAIT: begin
					if (pair_done) begin
						acc_q <= (acc_new > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : acc_new[SUM_W-1:0];
						if (j_last) begin
							state_q <= ST_ROW_END;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= ST_PAIR_RD;
						end
					end
				end
				ST_ROW_END: begin
					if (i_last) begin
						o_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= ST_ROW_RD;
					end
				end
				ST_EMIT_RD: begin
					if (out_free) begin
						state_q <= ST_EMIT_LAT;
					end
				end
				ST_EMIT_LAT: begin
					out_valid_q    <= 1'b1;
					atom_index_q   <= IDXO_W'(o_q);
					coord_number_q <= sum_rdata_q;
					bad_element_q  <= 1'b0;
					last_result_q  <= o_last;
					if (o_last) begin
						count_q <= '0;
						err_q   <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						o_q     <= o_q + IDX_W'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_ERR: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						atom_index_q   <= '0;
						coord_number_q <= '0;
						bad_element_q  <= 1'b1;
						last_result_q  <= 1'b1;
						count_q        <= '0;
						err_q          <= 1'b0;
						state_q        <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign atom_index   = atom_index_q;
	assign coord_number = coord_number_q;
	assign bad_element  = bad_element_q;
	assign last_result  = last_result_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ATOMS))
		else $error("atom count above capacity");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAIR_RD |-> j_q < i_q)
		else $error("pair index not below row index");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_element |-> last_result && coord_number == '0 && atom_index == '0)
		else $error("error result malformed");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_atom |=> !in_ready)
		else $error("input still taken after final atom");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LAT |-> $past(out_free))
		else $error("result loaded over pending result");

endmodule

`default_nettype wire
